>>> rtl/bped_pkg.sv
// ----------------------------------------------------------------------------
// bped_pkg: shared definitions of the button press event detector
// Holds the result codes, the register indexes, the debounce time and the
// types passed between the top level and the state tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bped_pkg;

    // Default width of the time stamps and time differences.
    localparam int TIME_BITS_DEF = 32;

    // Fixed widths of the item fields.
    localparam int NOW_W   = 32;
    localparam int CODE_W  = 4;
    localparam int LIMIT_W = 16;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((1 + NOW_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CODE_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = LIMIT_W;

    // A press is only taken more than this many ms after the last released poll.
    localparam int unsigned DEBOUNCE_MS = 50;

    // Reported codes of the event states.
    localparam logic [CODE_W-1:0] CODE_CLICK    = 4'd2;
    localparam logic [CODE_W-1:0] CODE_LONG     = 4'd3;
    localparam logic [CODE_W-1:0] CODE_DOUBLE   = 4'd5;
    localparam logic [CODE_W-1:0] CODE_RELEASED = 4'd7;

    // Reported code for a poll whose pin read failed.
    localparam logic [CODE_W-1:0] CODE_ERROR = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_TIME   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIN   = 8'd3;

    // Register reset values.
    localparam logic [LIMIT_W-1:0] CLICK_TIME_RST = 16'd50;
    localparam logic [LIMIT_W-1:0] LONG_TIME_RST  = 16'd1000;
    localparam logic [LIMIT_W-1:0] DOUBLE_WIN_RST = 16'd300;

    // Configuration seen by the state tracker.
    typedef struct packed {
        logic               active_level;
        logic [LIMIT_W-1:0] click_time_ms;
        logic [LIMIT_W-1:0] long_time_ms;
        logic [LIMIT_W-1:0] double_window_ms;
    } bped_cfg_t;

    // One poll as held in the input register.
    typedef struct packed {
        logic             pin_level;
        logic [NOW_W-1:0] now_ms;
        logic             read_fault;
    } bped_poll_t;

    // Result of one poll.
    typedef struct packed {
        logic [CODE_W-1:0] button_state;
        logic              event_fired;
    } bped_result_t;

endpackage

`default_nettype wire

>>> rtl/bped_tracker.sv
// ----------------------------------------------------------------------------
// bped_tracker: button state and time stamp tracking
// Holds the prior state and the press, release and click stamps, and works
// out the result of one poll in a single combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bped_tracker
    import bped_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step_en,   // commit the poll below
    input  var  bped_poll_t   poll,
    input  var  bped_cfg_t    cfg,
    output bped_result_t      result
);

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_HELD        = 3'd1,
        ST_CLICK       = 3'd2,
        ST_LONG        = 3'd3,
        ST_LONG_HELD   = 3'd4,
        ST_DOUBLE      = 3'd5,
        ST_DOUBLE_HELD = 3'd6,
        ST_RELEASED    = 3'd7
    } state_t;

    state_t               state_reg, state_next;
    logic [TIME_BITS-1:0] press_reg, press_next;
    logic [TIME_BITS-1:0] release_reg, release_next;
    logic [TIME_BITS-1:0] click_reg, click_next;
    logic                 fire;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] since_press, since_release, since_click;
    logic [TIME_BITS-1:0] debounce_t;
    logic [TIME_BITS-1:0] click_lim, long_lim, double_lim;
    logic                 pressed;

    // Wrapping time differences against the stored stamps.
    assign now_t         = TIME_BITS'(poll.now_ms);
    assign since_press   = now_t - press_reg;
    assign since_release = now_t - release_reg;
    assign since_click   = now_t - click_reg;
    assign debounce_t    = TIME_BITS'(DEBOUNCE_MS);
    assign click_lim     = TIME_BITS'(cfg.click_time_ms);
    assign long_lim      = TIME_BITS'(cfg.long_time_ms);
    assign double_lim    = TIME_BITS'(cfg.double_window_ms);
    assign pressed       = (poll.pin_level == cfg.active_level);

    // Next state and stamps for a poll without read fault.
    always_comb begin
        state_next   = state_reg;
        press_next   = press_reg;
        release_next = release_reg;
        click_next   = click_reg;
        fire         = 1'b0;
        if (state_reg == ST_RELEASED) begin
            state_next = ST_IDLE;
        end else if (state_reg == ST_CLICK) begin
            state_next = ST_HELD;
        end
        if (pressed) begin
            press_next = now_t;
            unique case (state_reg)
                ST_IDLE: begin
                    if (since_release > debounce_t) begin
                        state_next = ST_HELD;
                    end
                end
                ST_HELD: begin
                    // Long press wins over a double press on the same poll.
                    if (since_release > long_lim) begin
                        state_next = ST_LONG;
                        fire       = 1'b1;
                    end else if (since_click < double_lim) begin
                        state_next = ST_DOUBLE;
                        fire       = 1'b1;
                    end
                end
                ST_LONG:   state_next = ST_LONG_HELD;
                ST_DOUBLE: state_next = ST_DOUBLE_HELD;
                default: ;
            endcase
        end else begin
            release_next = now_t;
            unique case (state_reg)
                ST_HELD: begin
                    if (since_press > click_lim) begin
                        state_next = ST_CLICK;
                        fire       = 1'b1;
                        press_next = now_t;
                    end else if (since_press > debounce_t) begin
                        click_next = now_t;
                    end
                end
                ST_CLICK, ST_LONG, ST_LONG_HELD: begin
                    state_next = ST_RELEASED;
                    fire       = 1'b1;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    // A faulted poll reports the error code and leaves everything as it is.
    always_comb begin
        if (poll.read_fault) begin
            result.button_state = CODE_ERROR;
            result.event_fired  = 1'b0;
        end else begin
            result.button_state = {1'b0, state_next};
            result.event_fired  = fire;
        end
    end

    // State and stamp registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            press_reg   <= '0;
            release_reg <= '0;
            click_reg   <= '0;
        end else if (step_en && !poll.read_fault) begin
            state_reg   <= state_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            click_reg   <= click_next;
        end
    end

    // A faulted poll changes no state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && poll.read_fault |=> $stable(state_reg) && $stable(press_reg)
            && $stable(release_reg) && $stable(click_reg))
    else $error("tracker state changed on a faulted poll");

    // Double held is only entered from double.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && state_reg == ST_DOUBLE_HELD && !$stable(state_reg)
            |-> $past(state_reg) == ST_DOUBLE)
    else $error("double held entered from a wrong state");

    // Nothing moves without a committed poll.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(state_reg) && $stable(click_reg))
    else $error("tracker state changed without a poll");

endmodule

`default_nettype wire

>>> rtl/button_press_event_detector.sv
// ----------------------------------------------------------------------------
// button_press_event_detector: click, long and double press detection
// Turns a stream of button polls into button states and event flags.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ channel is one poll of the button: the sampled pin
//   level and the millisecond time in s_tdata, a read-fault flag in s_tuser.
//   Each poll yields exactly one item on the m_ channel: the button state
//   code in m_tdata and the event flag in m_tuser.
//   The cfg_ channel writes the active level and the three time limits;
//   it is always ready and should be used only while no poll is in flight.
//   An accepted poll passes the input register, then the state update and
//   the result register, which load together. One poll is accepted in
//   every cycle while the receiver takes results, as the state update is a
//   single pass of subtract-compare logic over the stored time stamps.
//   When the receiver stalls, the result register holds its item and the
//   input register takes one more poll; s_tready then falls until the
//   result is taken.
//   Reset clears the valid flags of both registers, returns the button to
//   idle, zeros the stamps and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_event_detector
    import bped_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Poll channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [0] pin_level, [32:1] now_ms
    input  wire logic                  s_tuser,   // [0] read_fault
    // Result channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [3:0] button_state
    output logic                       m_tuser,   // [0] event_fired
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    bped_cfg_t    cfg_reg;
    bped_poll_t   poll_reg;
    logic         in_vld_reg;
    bped_result_t res_reg;
    bped_result_t res_next;
    logic         out_vld_reg;
    logic         advance;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level     <= 1'b0;
            cfg_reg.click_time_ms    <= CLICK_TIME_RST;
            cfg_reg.long_time_ms     <= LONG_TIME_RST;
            cfg_reg.double_window_ms <= DOUBLE_WIN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ACTIVE_LEVEL: cfg_reg.active_level     <= cfg_data[0];
                REG_CLICK_TIME:   cfg_reg.click_time_ms    <= cfg_data;
                REG_LONG_TIME:    cfg_reg.long_time_ms     <= cfg_data;
                REG_DOUBLE_WIN:   cfg_reg.double_window_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    // The held poll moves on when the result register is free or draining.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            poll_reg.pin_level  <= s_tdata[0];
            poll_reg.now_ms     <= s_tdata[NOW_W:1];
            poll_reg.read_fault <= s_tuser;
        end
    end

    // State tracking and next result.
    bped_tracker #(
        .TIME_BITS (TIME_BITS)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .poll    (poll_reg),
        .cfg     (cfg_reg),
        .result  (res_next)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_TDATA_W'(res_reg.button_state);
    assign m_tuser  = res_reg.event_fired;

    // An event is only flagged on click, long, double or released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[CODE_W-1:0] == CODE_CLICK
            || m_tdata[CODE_W-1:0] == CODE_LONG || m_tdata[CODE_W-1:0] == CODE_DOUBLE
            || m_tdata[CODE_W-1:0] == CODE_RELEASED)
    else $error("event flag on a state that is no event");

    // An error result never carries an event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[CODE_W-1:0] == CODE_ERROR |-> !m_tuser)
    else $error("event flag on an error result");

    // Both registers full and the receiver stalled: no new poll is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_tready |-> !s_tready)
    else $error("poll taken while both registers are full");

endmodule

`default_nettype wire
